// ===== src/mecanum_odometry_integrator_core_assert.svh =====
// ----------------------------------------------------------------------------
// mecanum odometry assertion macros
// concurrent check helpers on clk with asynchronous reset rst_n
// ----------------------------------------------------------------------------
`ifndef MECANUM_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH
`define MECANUM_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH

// same-cycle implication
`define MOI_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed");

// next-cycle implication
`define MOI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed");

`endif

// ===== src/moi_pkg.sv =====
// ----------------------------------------------------------------------------
// mecanum odometry package
// sequencer states, register indexes, fixed constants and the atan table
// ----------------------------------------------------------------------------
`default_nettype none

package moi_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MVX,
        ST_MVY,
        ST_MWZ,
        ST_DINIT,
        ST_ITER,
        ST_WZFIN,
        ST_MVYS,
        ST_MVXS,
        ST_MVYC,
        ST_MWXDT,
        ST_MWYDT,
        ST_MWZDT,
        ST_MPHK,
        ST_MPLK,
        ST_HFIN
    } state_t;

    typedef enum logic [1:0] {
        REG_WHEEL_RADIUS = 2'd0,
        REG_TRACK_WIDTH  = 2'd1,
        REG_WHEEL_BASE   = 2'd2
    } reg_index_t;

    localparam logic [15:0] RADIUS_RESET = 16'd4915;
    localparam logic [17:0] TRACK_RESET  = 18'd26214;
    localparam logic [17:0] BASE_RESET   = 18'd26214;
    localparam logic [19:0] DT_LIMIT     = 20'd131072;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] TURN_PER_RAD = 34'sd683565276;
    localparam logic [5:0] DIV_LAST      = 6'd42;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/mecanum_odometry_integrator_core.sv =====
// ----------------------------------------------------------------------------
// mecanum odometry integrator
// wheel speeds to body velocities, rotated by heading and integrated to pose
// ----------------------------------------------------------------------------
// The input is not ready while an item is in work, which is paced by the
// 43-step restoring divider for the yaw rate, running alongside the
// CORDIC rotations (CORDIC_STEPS of them), and by one shared 34x34
// signed multiplier issued a product per cycle for the remaining terms. An
// item with elapsed time above 2 s returns to idle at once and gives no result.
// The next item is taken while a result still waits in the output register.
`default_nettype none

module mecanum_odometry_integrator_core
    import moi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // right_front_speed, left_front_speed, left_rear_speed, right_rear_speed,
    // elapsed_time, zero pad
    input  wire logic [87:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x, pos_y, heading_angle, vel_x, vel_y, yaw_rate
    output logic [191:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [17:0]  cfg_data
);

    state_t state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic        out_valid_reg;

    logic [15:0] radius_reg;
    logic [17:0] track_reg;
    logic [17:0] base_reg;

    logic signed [31:0] pose_x_reg, pose_y_reg;
    logic [31:0] heading_reg;

    logic signed [17:0] sumx_reg, sumy_reg, sumw_reg;
    logic [19:0] dt_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg, acc_reg;

    logic signed [31:0] vx_reg, vy_reg, wz_reg;
    logic signed [33:0] w_reg;
    logic [31:0] pl_reg;

    logic [19:0] den_reg;
    logic [20:0] rem_reg;
    logic [42:0] q_reg;
    logic        neg_reg;

    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic        flip_reg;

    logic [31:0] o_px_reg, o_py_reg, o_h_reg, o_vx_reg, o_vy_reg, o_wz_reg;

    logic signed [17:0] rf, lf, lr, rr;
    logic [19:0] in_dt;
    logic        in_fire, hfin_fire;
    logic [18:0] den_half;
    logic [20:0] rem_sh;
    logic [4:0]  step_i;
    logic [31:0] ang_shift;
    logic signed [42:0] numer;
    logic signed [67:0] q_signed;
    logic [31:0] dh;

    function automatic logic [31:0] sat32(input logic signed [67:0] v);
        logic [31:0] r;
        if ((&v[67:31]) || !(|v[67:31]))
            r = v[31:0];
        else if (v[67])
            r = 32'h80000000;
        else
            r = 32'h7FFFFFFF;
        return r;
    endfunction

    assign rf = {{2{s_tdata[15]}}, s_tdata[15:0]};
    assign lf = {{2{s_tdata[31]}}, s_tdata[31:16]};
    assign lr = {{2{s_tdata[47]}}, s_tdata[47:32]};
    assign rr = {{2{s_tdata[63]}}, s_tdata[63:48]};
    assign in_dt = s_tdata[83:64];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign hfin_fire = (state_reg == ST_HFIN) && (!out_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {o_wz_reg, o_vy_reg, o_vx_reg, o_h_reg, o_py_reg, o_px_reg};

    assign den_half = {1'b0, track_reg} + {1'b0, base_reg};
    assign rem_sh   = {rem_reg[19:0], q_reg[42]};
    assign step_i   = cnt_reg[4:0];
    assign ang_shift = heading_reg + 32'h40000000;
    assign numer    = {prod_reg[34:0], 8'd0};
    assign q_signed = neg_reg ? -$signed({25'd0, q_reg}) : $signed({25'd0, q_reg});
    assign dh       = acc_reg[31:0] + prod_reg[63:32];

    always_comb
    begin
        state_next = state_reg;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_dt <= DT_LIMIT)
                    state_next = ST_MVX;
            end
            ST_MVX:
            begin
                mul_a = {18'd0, radius_reg};
                mul_b = 34'(sumx_reg);
                state_next = ST_MVY;
            end
            ST_MVY:
            begin
                mul_a = {18'd0, radius_reg};
                mul_b = 34'(sumy_reg);
                state_next = ST_MWZ;
            end
            ST_MWZ:
            begin
                mul_a = {18'd0, radius_reg};
                mul_b = 34'(sumw_reg);
                state_next = ST_DINIT;
            end
            ST_DINIT:
                state_next = ST_ITER;
            ST_ITER:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_WZFIN;
            end
            ST_WZFIN:
            begin
                mul_a = 34'(vx_reg);
                mul_b = flip_reg ? -cx_reg : cx_reg;
                state_next = ST_MVYS;
            end
            ST_MVYS:
            begin
                mul_a = 34'(vy_reg);
                mul_b = cy_reg;
                state_next = ST_MVXS;
            end
            ST_MVXS:
            begin
                mul_a = 34'(vx_reg);
                mul_b = cy_reg;
                state_next = ST_MVYC;
            end
            ST_MVYC:
            begin
                mul_a = 34'(vy_reg);
                mul_b = cx_reg;
                state_next = ST_MWXDT;
            end
            ST_MWXDT:
            begin
                mul_a = w_reg;
                mul_b = {14'd0, dt_reg};
                state_next = ST_MWYDT;
            end
            ST_MWYDT:
            begin
                mul_a = w_reg;
                mul_b = {14'd0, dt_reg};
                state_next = ST_MWZDT;
            end
            ST_MWZDT:
            begin
                mul_a = 34'(wz_reg);
                mul_b = {14'd0, dt_reg};
                state_next = ST_MPHK;
            end
            ST_MPHK:
            begin
                mul_a = 34'($signed(prod_reg[51:32]));
                mul_b = TURN_PER_RAD;
                state_next = ST_MPLK;
            end
            ST_MPLK:
            begin
                mul_a = {2'd0, pl_reg};
                mul_b = TURN_PER_RAD;
                state_next = ST_HFIN;
            end
            ST_HFIN:
            begin
                // hold the low product while the result waits
                mul_a = {2'd0, pl_reg};
                mul_b = TURN_PER_RAD;
                if (hfin_fire)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            radius_reg    <= RADIUS_RESET;
            track_reg     <= TRACK_RESET;
            base_reg      <= BASE_RESET;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            heading_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ITER)
                cnt_reg <= cnt_reg + 6'd1;
            else
                cnt_reg <= '0;
            if (hfin_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_WHEEL_RADIUS: radius_reg <= cfg_data[15:0];
                    REG_TRACK_WIDTH:  track_reg  <= cfg_data;
                    REG_WHEEL_BASE:   base_reg   <= cfg_data;
                    default:          ;
                endcase
            end
            if (state_reg == ST_MWYDT)
                pose_x_reg <= pose_x_reg + prod_reg[47:16];
            if (state_reg == ST_MWZDT)
                pose_y_reg <= pose_y_reg + prod_reg[47:16];
            if (hfin_fire)
                heading_reg <= heading_reg + dh;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                sumx_reg <= rf + lf + lr + rr;
                sumy_reg <= lf - rf + rr - lr;
                sumw_reg <= rf - lf + rr - lr;
                dt_reg   <= in_dt;
            end
            ST_MVY:
                vx_reg <= sat32(prod_reg >>> 10);
            ST_MWZ:
                vy_reg <= sat32(prod_reg >>> 10);
            ST_DINIT:
            begin
                neg_reg  <= numer[42];
                q_reg    <= numer[42] ? 43'(-numer) : 43'(numer);
                rem_reg  <= '0;
                den_reg  <= {den_half, 1'b0};
                flip_reg <= ang_shift[31];
                cz_reg   <= 33'($signed({heading_reg[31] ^ ang_shift[31],
                                         heading_reg[30:0]}));
                cx_reg   <= CORDIC_GAIN;
                cy_reg   <= '0;
            end
            ST_ITER:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    q_reg   <= {q_reg[41:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[41:0], 1'b0};
                end
                if (32'(cnt_reg) < 32'(CORDIC_STEPS))
                begin
                    if (!cz_reg[32])
                    begin
                        cx_reg <= cx_reg - (cy_reg >>> step_i);
                        cy_reg <= cy_reg + (cx_reg >>> step_i);
                        cz_reg <= cz_reg - $signed({1'b0, atan_turn(step_i)});
                    end
                    else
                    begin
                        cx_reg <= cx_reg + (cy_reg >>> step_i);
                        cy_reg <= cy_reg - (cx_reg >>> step_i);
                        cz_reg <= cz_reg + $signed({1'b0, atan_turn(step_i)});
                    end
                end
            end
            ST_WZFIN:
            begin
                wz_reg <= (den_reg == '0) ? '0 : sat32(q_signed);
                if (flip_reg)
                begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                end
            end
            ST_MVYS:
                acc_reg <= prod_reg;
            ST_MVXS:
                w_reg <= 34'((acc_reg - prod_reg) >>> 30);
            ST_MVYC:
                acc_reg <= prod_reg;
            ST_MWXDT:
                w_reg <= 34'((acc_reg + prod_reg) >>> 30);
            ST_MPHK:
                pl_reg <= prod_reg[31:0];
            ST_MPLK:
                acc_reg <= prod_reg;
            ST_HFIN:
            begin
                if (hfin_fire)
                begin
                    o_px_reg <= pose_x_reg;
                    o_py_reg <= pose_y_reg;
                    o_h_reg  <= heading_reg + dh;
                    o_vx_reg <= vx_reg;
                    o_vy_reg <= vy_reg;
                    o_wz_reg <= wz_reg;
                end
            end
            default:
                ;
        endcase
    end

    `include "mecanum_odometry_integrator_core_assert.svh"

    `MOI_ASSERT_NEXT(a_div_done, (state_reg == ST_ITER) && (cnt_reg == DIV_LAST), state_reg == ST_WZFIN)
    `MOI_ASSERT_NEXT(a_skip_long, in_fire && (in_dt > DT_LIMIT), state_reg == ST_IDLE)
    `MOI_ASSERT_NEXT(a_result_out, hfin_fire, out_valid_reg && (state_reg == ST_IDLE))
    `MOI_ASSERT_IMP(a_busy_not_ready, state_reg != ST_IDLE, !s_tready)

endmodule

`default_nettype wire
